@@ sv/ctsvf_pkg.sv @@
// shared types, constants and arithmetic helpers of the cascaded state variable filter
package ctsvf_pkg;

    localparam int MaxStagesDef   = 4;
    localparam int ChannelsDef    = 2;
    localparam int SampleWidthDef = 24;

    localparam int FracBits = 22;
    localparam int StateW   = 32;
    localparam int CoefW    = 34;

    localparam logic [CoefW-1:0] InvQ707 = 34'd5932537;

    // register indexes
    localparam logic [2:0] RegCutoff  = 3'd0;
    localparam logic [2:0] RegDamp    = 3'd1;
    localparam logic [2:0] RegNorm1   = 3'd2;
    localparam logic [2:0] RegNormR   = 3'd3;
    localparam logic [2:0] RegType    = 3'd4;
    localparam logic [2:0] RegStages  = 3'd5;

    // response codes
    localparam logic [1:0] TypeLp = 2'd0;
    localparam logic [1:0] TypeHp = 2'd1;
    localparam logic [1:0] TypeBp = 2'd2;

    // multiply steps of one stage
    typedef enum logic [2:0] {
        t_ph_idle, t_ph_t, t_ph_hp, t_ph_gh, t_ph_gb, t_ph_y
    } t_phase;

    // saturate a wide sum to the signed 32-bit range
    function automatic logic signed [StateW-1:0] sat32(input logic signed [67:0] v);
        logic signed [67:0] hi;
        logic signed [67:0] lo;
        hi = 68'sd2147483647;
        lo = -68'sd2147483648;
        if (v > hi) sat32 = 32'sh7fffffff;
        else if (v < lo) sat32 = 32'sh80000000;
        else sat32 = v[StateW-1:0];
    endfunction

endpackage

@@ sv/ctsvf_cell.sv @@
// one filter stage: holds the integrators of all channels and works one sample through
module ctsvf_cell #(
    parameter int CHANNELS = ctsvf_pkg::ChannelsDef,
    parameter int CH_W     = 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_clear,
    input  logic                               i_start,
    input  logic                               i_first,
    input  logic [CH_W-1:0]                    i_ch,
    input  logic signed [ctsvf_pkg::StateW-1:0] i_x,
    input  logic [31:0]                        i_g,
    input  logic [23:0]                        i_r2,
    input  logic [22:0]                        i_h,
    input  logic [1:0]                         i_type,
    output logic                               o_done,
    output logic signed [ctsvf_pkg::StateW-1:0] o_y
);
    localparam int W = ctsvf_pkg::StateW;

    logic signed [W-1:0] r_s1 [CHANNELS];
    logic signed [W-1:0] r_s2 [CHANNELS];
    logic signed [W-1:0] r_x, r_hp, r_bp, r_y;
    logic [CH_W-1:0] r_ch;
    ctsvf_pkg::t_phase r_ph, n_ph;
    logic r_done;

    logic signed [W-1:0] s1, s2;
    logic signed [W-1:0] m_a;
    logic [ctsvf_pkg::CoefW-1:0] m_b;
    logic signed [67:0] prod, fl;
    logic signed [W-1:0] m_res;
    logic signed [W-1:0] bp_now, lp_now;
    logic [1:0] ty;

    assign s1 = r_s1[r_ch];
    assign s2 = r_s2[r_ch];
    assign ty = (i_type == 2'd3) ? ctsvf_pkg::TypeLp : i_type;

    // operand select for the shared multiplier
    always_comb begin
        m_a = r_hp;
        m_b = {2'b0, i_g};
        unique case (r_ph)
            ctsvf_pkg::t_ph_t: begin
                m_a = s1;
                m_b = {2'b0, i_g} + (i_first ? {10'b0, i_r2} : ctsvf_pkg::InvQ707);
            end
            ctsvf_pkg::t_ph_hp: begin
                m_a = r_x;
                m_b = {11'b0, i_h};
            end
            ctsvf_pkg::t_ph_gh: begin
                m_a = r_hp;
                m_b = {2'b0, i_g};
            end
            ctsvf_pkg::t_ph_gb: begin
                m_a = r_bp;
                m_b = {2'b0, i_g};
            end
            ctsvf_pkg::t_ph_y: begin
                m_a = r_bp;
                m_b = ctsvf_pkg::InvQ707;
            end
            default: begin
                m_a = r_hp;
                m_b = {2'b0, i_g};
            end
        endcase
    end

    // product with floor toward minus infinity (arithmetic shift floors)
    assign prod  = 68'(m_a) * $signed({34'b0, m_b});
    assign fl    = prod >>> ctsvf_pkg::FracBits;
    assign m_res = ctsvf_pkg::sat32(fl);
    assign bp_now = ctsvf_pkg::sat32(68'(m_res) + 68'(s1));
    assign lp_now = ctsvf_pkg::sat32(68'(m_res) + 68'(s2));

    // step sequence
    always_comb begin
        n_ph = r_ph;
        unique case (r_ph)
            ctsvf_pkg::t_ph_idle: if (i_start) n_ph = ctsvf_pkg::t_ph_t;
            ctsvf_pkg::t_ph_t:    n_ph = ctsvf_pkg::t_ph_hp;
            ctsvf_pkg::t_ph_hp:   n_ph = ctsvf_pkg::t_ph_gh;
            ctsvf_pkg::t_ph_gh:   n_ph = ctsvf_pkg::t_ph_gb;
            ctsvf_pkg::t_ph_gb:   n_ph = (ty == ctsvf_pkg::TypeBp && !i_first) ?
                                          ctsvf_pkg::t_ph_y : ctsvf_pkg::t_ph_idle;
            ctsvf_pkg::t_ph_y:    n_ph = ctsvf_pkg::t_ph_idle;
            default:              n_ph = ctsvf_pkg::t_ph_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= ctsvf_pkg::t_ph_idle;
            r_done <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_done <= (r_ph == ctsvf_pkg::t_ph_y) ||
                      (r_ph == ctsvf_pkg::t_ph_gb && n_ph == ctsvf_pkg::t_ph_idle);
        end
    end

    // datapath and integrators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_s1[c] <= '0;
                r_s2[c] <= '0;
            end
        end else begin
            unique case (r_ph)
                ctsvf_pkg::t_ph_gh: r_s1[r_ch] <= ctsvf_pkg::sat32(68'(m_res) + 68'(bp_now));
                ctsvf_pkg::t_ph_gb: r_s2[r_ch] <= ctsvf_pkg::sat32(68'(m_res) + 68'(lp_now));
                default: ;
            endcase
        end
        unique case (r_ph)
            ctsvf_pkg::t_ph_idle: begin
                if (i_start) begin
                    r_x  <= i_x;
                    r_ch <= i_ch;
                end
            end
            ctsvf_pkg::t_ph_t:
                r_x <= ctsvf_pkg::sat32(68'(ctsvf_pkg::sat32(68'(r_x) - 68'(m_res))) - 68'(s2));
            ctsvf_pkg::t_ph_hp: r_hp <= m_res;
            ctsvf_pkg::t_ph_gh: r_bp <= bp_now;
            ctsvf_pkg::t_ph_gb: begin
                unique case (ty)
                    ctsvf_pkg::TypeHp: r_y <= r_hp;
                    ctsvf_pkg::TypeBp: r_y <= r_bp;
                    default:           r_y <= lp_now;
                endcase
            end
            ctsvf_pkg::t_ph_y: r_y <= m_res;
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_y    = r_y;

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("stage done held");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph != ctsvf_pkg::t_ph_idle) |-> !i_start) else $error("stage restarted busy");
    a_y_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == ctsvf_pkg::t_ph_y) |-> !i_first) else $error("scale step on first stage");
`endif
endmodule

@@ sv/cascaded_tpt_state_variable_filter.sv @@
// top level: cascade of filter cells, configuration registers and stream handshake
// Usage:
//   Samples enter on the s_axis channel: tdata holds sample_in, tuser the channel.
//   Filtered samples leave on m_axis: tdata holds sample_out.
//   Coefficients and mode are written on the cfg channel (index, data); writes are
//   taken while no sample is being worked, and a write of type or stage count clears
//   all integrator states.
//   One sample is worked at a time. It passes the cells in order; each cell uses
//   its single shared multiplier for four steps (five in bandpass after the first
//   cell) and then hands its result on to the next cell in use.
//   The next sample is taken once the result has been transferred, so a new sample
//   is not taken before the last one has left.
//   A stalled receiver holds the output register and input is refused until it drains.
//   Synchronous active-low reset loads the register defaults and zeros all states.
module cascaded_tpt_state_variable_filter #(
    parameter int MAX_STAGES   = ctsvf_pkg::MaxStagesDef,
    parameter int CHANNELS     = ctsvf_pkg::ChannelsDef,
    parameter int SAMPLE_WIDTH = ctsvf_pkg::SampleWidthDef
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata, // sample_in
    input  logic                    s_axis_tuser,           // channel
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata, // sample_out
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [2:0]              i_cfg_index,
    input  logic [31:0]             i_cfg_data
);
    localparam int W    = ctsvf_pkg::StateW;
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SC_W = $clog2(MAX_STAGES + 1);
    localparam int TW   = ((SAMPLE_WIDTH+7)/8)*8;

    logic [31:0] r_g;
    logic [23:0] r_r2;
    logic [22:0] r_h1, r_hr;
    logic [1:0]  r_type;
    logic [2:0]  r_sc;
    logic        r_busy, r_ov;
    logic [SAMPLE_WIDTH-1:0] r_out;
    logic clear;
    logic cfg_wr;

    logic               go   [MAX_STAGES];
    logic               done [MAX_STAGES];
    logic signed [W-1:0] yv  [MAX_STAGES];
    logic [CH_W-1:0] chs;
    logic [SC_W-1:0] nst;
    logic signed [W-1:0] x_in;
    logic signed [W-1:0] last_y;
    logic last_done;

    assign o_cfg_ready   = !r_busy;
    assign cfg_wr        = i_cfg_valid && o_cfg_ready;
    assign clear         = cfg_wr && (i_cfg_index == ctsvf_pkg::RegType ||
                                      i_cfg_index == ctsvf_pkg::RegStages);
    assign s_axis_tready = !r_busy && !r_ov;
    // channel field is one bit, so it only folds to zero with a single channel
    assign chs  = (CHANNELS > 1) ? CH_W'(s_axis_tuser) : CH_W'(0);
    assign x_in = W'($signed(s_axis_tdata[SAMPLE_WIDTH-1:0]));

    // stage count clamp
    always_comb begin
        if (r_sc == 3'd0) nst = SC_W'(1);
        else if (32'(r_sc) > MAX_STAGES) nst = SC_W'(MAX_STAGES);
        else nst = SC_W'(r_sc);
    end

    // chain of cells
    for (genvar k = 0; k < MAX_STAGES; k++) begin : g_cell
        logic signed [W-1:0] xk;
        logic [CH_W-1:0] r_chk;
        logic [CH_W-1:0] chk;
        if (k == 0) begin : g_head
            assign go[k] = s_axis_tvalid && s_axis_tready;
            assign xk    = x_in;
            assign chk   = chs;
            always_ff @(posedge i_clk) if (go[k]) r_chk <= chs;
        end else begin : g_link
            assign go[k] = done[k-1] && (32'(nst) > k);
            assign xk    = yv[k-1];
            assign chk   = g_cell[k-1].r_chk;
            always_ff @(posedge i_clk) if (go[k]) r_chk <= g_cell[k-1].r_chk;
        end
        ctsvf_cell #(.CHANNELS(CHANNELS), .CH_W(CH_W)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(clear), .i_start(go[k]),
            .i_first(k == 0), .i_ch(chk),
            .i_x(xk), .i_g(r_g), .i_r2(r_r2), .i_h((k == 0) ? r_h1 : r_hr),
            .i_type(r_type), .o_done(done[k]), .o_y(yv[k])
        );
    end

    // pick the last stage in use
    always_comb begin
        last_done = 1'b0;
        last_y    = yv[0];
        for (int k = 0; k < MAX_STAGES; k++) begin
            if (32'(nst) == k + 1) begin
                last_done = done[k];
                last_y    = yv[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g <= 32'd4194304; r_r2 <= 24'd5931642;
            r_h1 <= 23'd1048576; r_hr <= 23'd1048576;
            r_type <= ctsvf_pkg::TypeLp; r_sc <= 3'd1;
            r_busy <= 1'b0; r_ov <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    ctsvf_pkg::RegCutoff: r_g    <= i_cfg_data;
                    ctsvf_pkg::RegDamp:   r_r2   <= i_cfg_data[23:0];
                    ctsvf_pkg::RegNorm1:  r_h1   <= i_cfg_data[22:0];
                    ctsvf_pkg::RegNormR:  r_hr   <= i_cfg_data[22:0];
                    ctsvf_pkg::RegType:   r_type <= i_cfg_data[1:0];
                    ctsvf_pkg::RegStages: r_sc   <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (go[0]) r_busy <= 1'b1;
            else if (last_done) r_busy <= 1'b0;
            if (last_done) r_ov <= 1'b1;
            else if (m_axis_tready) r_ov <= 1'b0;
        end
    end

    // output saturation register
    always_ff @(posedge i_clk) begin
        if (last_done) begin
            if (last_y > W'((64'sd1 <<< (SAMPLE_WIDTH-1)) - 1))
                r_out <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            else if (last_y < -W'(64'sd1 <<< (SAMPLE_WIDTH-1)))
                r_out <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            else
                r_out <= last_y[SAMPLE_WIDTH-1:0];
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = TW'(r_out);

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !s_axis_tready) else $error("input taken while busy");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_done |-> r_busy) else $error("result without sample");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_axis_tready) |=> r_ov) else $error("result lost");
`endif
endmodule

@@ verif/cascaded_tpt_state_variable_filter_tb.sv @@
// self-checking testbench of the cascaded state variable filter with its own predictor
module cascaded_tpt_state_variable_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NStages = 4;
    localparam int NChan   = 2;
    localparam int SampW   = 24;
    localparam longint unsigned InvQ = 64'd5932537;

    typedef struct packed {
        logic             chan;
        logic [SampW-1:0] sample;
    } t_sample_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [SampW-1:0] s_axis_tdata = '0;   // sample_in
    logic s_axis_tuser = 1'b0;             // channel
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [SampW-1:0] m_axis_tdata;        // sample_out
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    cascaded_tpt_state_variable_filter dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor copy of registers and integrators
    longint unsigned cut_g, damp_r2, norm_first, norm_rest;
    logic [1:0] resp_sel;
    logic [2:0] n_stages;
    longint int1 [NStages*NChan];
    longint int2 [NStages*NChan];

    t_sample_item pending_samples[$];
    logic [SampW-1:0] expected_out[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;

    function automatic longint clamp(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // value times Q.22 coefficient, floor rounding, 32-bit saturation
    function automatic longint coef_mul(longint a, longint unsigned b);
        longint bh;
        longint bl;
        bh = longint'(b >> ctsvf_pkg::FracBits);
        bl = longint'(b & ((64'd1 << ctsvf_pkg::FracBits) - 1));
        return clamp(a * bh + ((a * bl) >>> ctsvf_pkg::FracBits), 32);
    endfunction

    function automatic void clear_integrators();
        foreach (int1[k]) begin
            int1[k] = 0;
            int2[k] = 0;
        end
    endfunction

    function automatic logic [SampW-1:0] filter_sample(logic chan, logic [SampW-1:0] raw);
        longint x;
        longint s1, s2, t, hp, gh, bp, gb, lp, y;
        longint unsigned r2, h;
        int ns;
        int k;
        x = longint'($signed(raw));
        ns = (n_stages < 1) ? 1 : ((n_stages > NStages) ? NStages : int'(n_stages));
        for (int i = 0; i < ns; i++) begin
            k = i * NChan + int'(chan);
            r2 = (i == 0) ? damp_r2 : InvQ;
            h = (i == 0) ? norm_first : norm_rest;
            s1 = int1[k];
            s2 = int2[k];
            t = clamp(clamp(x - coef_mul(s1, cut_g + r2), 32) - s2, 32);
            hp = coef_mul(t, h);
            gh = coef_mul(hp, cut_g);
            bp = clamp(gh + s1, 32);
            int1[k] = clamp(gh + bp, 32);
            gb = coef_mul(bp, cut_g);
            lp = clamp(gb + s2, 32);
            int2[k] = clamp(gb + lp, 32);
            if (resp_sel == ctsvf_pkg::TypeHp) y = hp;
            else if (resp_sel == ctsvf_pkg::TypeBp) y = (i > 0) ? coef_mul(bp, InvQ) : bp;
            else y = lp;
            x = y;
        end
        return SampW'(clamp(x, SampW));
    endfunction

    // sample driver and expectation on each input transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_out.push_back(filter_sample(s_axis_tuser, s_axis_tdata));
            if (s_axis_tvalid && !s_axis_tready) begin
                s_axis_tvalid <= 1'b1;
            end else if (pending_samples.size() > 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                t_sample_item it;
                it = pending_samples.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= it.chan;
                s_axis_tdata <= it.sample;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_out.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output transfer: %h", m_axis_tdata);
                end else begin
                    logic [SampW-1:0] want;
                    want = expected_out.pop_front();
                    if (want !== m_axis_tdata) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("sample_out mismatch: expected %h actual %h",
                                     want, m_axis_tdata);
                    end
                end
            end
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            ctsvf_pkg::RegCutoff: cut_g = val;
            ctsvf_pkg::RegDamp:   damp_r2 = val & 32'hFFFFFF;
            ctsvf_pkg::RegNorm1:  norm_first = val & 32'h7FFFFF;
            ctsvf_pkg::RegNormR:  norm_rest = val & 32'h7FFFFF;
            ctsvf_pkg::RegType: begin
                resp_sel = val[1:0];
                clear_integrators();
            end
            ctsvf_pkg::RegStages: begin
                n_stages = val[2:0];
                clear_integrators();
            end
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || s_axis_tvalid || expected_out.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_norm();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'd4194304;
            default: return $urandom_range(4194304);
        endcase
    endfunction

    function automatic logic [31:0] pick_cutoff();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'hFFFFFFFF;
            2: return $urandom;
            default: return $urandom_range(4194304);
        endcase
    endfunction

    initial begin
        logic [SampW-1:0] edge_vals [6];
        cut_g = 64'd4194304;
        damp_r2 = 64'd5931642;
        norm_first = 64'd1048576;
        norm_rest = 64'd1048576;
        resp_sel = ctsvf_pkg::TypeLp;
        n_stages = 3'd1;
        clear_integrators();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: sample extremes on both channels with reset defaults
        edge_vals = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001, 24'h7FFFFF};
        foreach (edge_vals[j]) begin
            pending_samples.push_back('{chan: 1'b0, sample: edge_vals[j]});
            pending_samples.push_back('{chan: 1'b1, sample: edge_vals[j]});
        end
        drain();

        // directed: each response, unused code, stage count extremes, unknown index
        for (int d = 0; d < 4; d++) begin
            reg_write(ctsvf_pkg::RegType, 32'(d));
            reg_write(ctsvf_pkg::RegStages,
                      (d == 0) ? 32'd0 : ((d == 1) ? 32'd7 : 32'(d + 2)));
            reg_write(3'd6 + 3'(d & 1), $urandom);
            i_cfg_valid <= 1'b0;
            pending_samples.push_back('{chan: 1'b0, sample: 24'h7FFFFF});
            pending_samples.push_back('{chan: 1'b1, sample: 24'h800000});
            pending_samples.push_back('{chan: 1'b0, sample: SampW'($urandom)});
            drain();
        end

        // random phases with varied settings and idling
        for (int p = 0; p < 13; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 85; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 85; end
                default: begin send_idle_pct = 23; recv_idle_pct = 23; end
            endcase
            reg_write(ctsvf_pkg::RegCutoff, pick_cutoff());
            reg_write(ctsvf_pkg::RegDamp,
                      (p == 3) ? 32'hFFFFFF : ((p == 4) ? 32'd0 : $urandom));
            reg_write(ctsvf_pkg::RegNorm1, pick_norm());
            reg_write(ctsvf_pkg::RegNormR, pick_norm());
            reg_write(ctsvf_pkg::RegType, $urandom_range(3));
            reg_write(ctsvf_pkg::RegStages, (p < 8) ? 32'(p % 4 + 1) : $urandom_range(7));
            i_cfg_valid <= 1'b0;
            for (int n = 0; n < 50; n++)
                pending_samples.push_back('{chan: 1'($urandom), sample: SampW'($urandom)});
            drain();
        end

        if (mismatches == 0 && expected_out.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
